/* rtl/dda_line_pixel_stepper_assert.svh */
// ----------------------------------------------------------------------------
// dda_line_pixel_stepper_assert.svh
// Assertion macros used by the checker of the line stepper.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_PIXEL_STEPPER_ASSERT_SVH
`define DDA_LINE_PIXEL_STEPPER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define DDA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants, codes and control types of the DDA line pixel stepper.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS    = 10;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_BITS      = COORD_BITS + FRAC_BITS;
    localparam int SCALE_BITS    = 5;
    localparam int COLOR_BITS    = 24;
    localparam int PIX_BITS      = 14;
    localparam int CFG_IDX_BITS  = 1;
    localparam int DIV_CNT_BITS  = $clog2(FRAC_BITS);
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * PIX_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic [SCALE_BITS-1:0] CELL_SCALE_RESET = 5'd1;
    localparam logic [COLOR_BITS-1:0] LINE_COLOR_RESET = 24'hFF0000;
    localparam logic [PIX_BITS-1:0]   PIXEL_MAX        = {PIX_BITS{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_CELL_SCALE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COLOR = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic div;
        logic div_last;
    } dda_cmd_t;

    typedef struct packed {
        logic steps_zero;
    } dda_sts_t;

endpackage

/* rtl/dda_ctrl.sv */
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: input handshake, division sequencing, line state, output valid.
// ----------------------------------------------------------------------------
module dda_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dda_pkg::dda_cmd_t cmd,
    input  dda_pkg::dda_sts_t sts
);
    import dda_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } dda_state_t;

    dda_state_t              state_reg;
    dda_state_t              state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic                    active_reg;
    logic                    active_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    in_fire;
    logic                    div_last;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign div_last = (state_reg == ST_DIV) && (cnt_reg == DIV_CNT_BITS'(FRAC_BITS - 1));

    assign cmd.load     = in_fire && (s_tuser == OP_LOAD);
    assign cmd.step     = in_fire && (s_tuser == OP_STEP) && active_reg;
    assign cmd.div      = (state_reg == ST_DIV);
    assign cmd.div_last = div_last;

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        if (cmd.load)
        begin
            active_next = 1'b1;
        end
        else if (cmd.step && sts.steps_zero)
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/dda_datapath.sv */
// ----------------------------------------------------------------------------
// dda_datapath
// Datapath: configuration registers, delta setup, shift-subtract divider,
// fixed-point accumulators and the scaled pixel output register.
// ----------------------------------------------------------------------------
module dda_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dda_pkg::dda_cmd_t                   cmd,
    output dda_pkg::dda_sts_t                   sts,
    input  logic [dda_pkg::IN_DATA_BITS-1:0]    in_data,
    input  logic                                cfg_valid,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [dda_pkg::COLOR_BITS-1:0]      cfg_data,
    output logic [dda_pkg::OUT_DATA_BITS-1:0]   out_data,
    output logic                                out_last
);
    import dda_pkg::*;

    localparam int PROD_BITS   = ACC_BITS + SCALE_BITS;
    localparam int SCALED_BITS = PROD_BITS - FRAC_BITS;

    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic                  x_major;
    logic [COORD_BITS-1:0] steps;
    logic [COORD_BITS-1:0] minor;

    logic [SCALE_BITS-1:0] cell_scale_reg;
    logic [COLOR_BITS-1:0] line_color_reg;

    logic [ACC_BITS-1:0]   accum_x_reg;
    logic [ACC_BITS-1:0]   accum_y_reg;
    logic [FRAC_BITS:0]    step_x_mag_reg;
    logic [FRAC_BITS:0]    step_y_mag_reg;
    logic                  neg_x_reg;
    logic                  neg_y_reg;
    logic [COORD_BITS-1:0] steps_left_reg;
    logic [COORD_BITS-1:0] steps_reg;
    logic [COORD_BITS:0]   rem_reg;
    logic [FRAC_BITS-1:0]  quot_reg;
    logic                  eq_reg;
    logic                  zero_reg;
    logic                  x_major_reg;

    logic [COORD_BITS:0]   rem_sh;
    logic                  rem_ge;
    logic [FRAC_BITS-1:0]  quot_next;
    logic [FRAC_BITS:0]    unit_mag;
    logic [FRAC_BITS:0]    minor_mag;

    logic [PROD_BITS-1:0]  prod_x;
    logic [PROD_BITS-1:0]  prod_y;
    logic [PIX_BITS-1:0]   pix_x;
    logic [PIX_BITS-1:0]   pix_y;

    logic [PIX_BITS-1:0]   out_x_reg;
    logic [PIX_BITS-1:0]   out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    function automatic logic [PIX_BITS-1:0] clamp_pixel(input logic [SCALED_BITS-1:0] v);
        logic [PIX_BITS-1:0] res;
        if (32'(v) > 32'(PIXEL_MAX))
        begin
            res = PIXEL_MAX;
        end
        else
        begin
            res = PIX_BITS'(v);
        end
        return res;
    endfunction

    assign start_x = in_data[0 * COORD_BITS +: COORD_BITS];
    assign start_y = in_data[1 * COORD_BITS +: COORD_BITS];
    assign end_x   = in_data[2 * COORD_BITS +: COORD_BITS];
    assign end_y   = in_data[3 * COORD_BITS +: COORD_BITS];

    assign neg_x   = end_x < start_x;
    assign neg_y   = end_y < start_y;
    assign mag_x   = neg_x ? (start_x - end_x) : (end_x - start_x);
    assign mag_y   = neg_y ? (start_y - end_y) : (end_y - start_y);
    assign x_major = mag_x >= mag_y;
    assign steps   = x_major ? mag_x : mag_y;
    assign minor   = x_major ? mag_y : mag_x;

    assign rem_sh    = {rem_reg[COORD_BITS-1:0], 1'b0};
    assign rem_ge    = rem_sh >= {1'b0, steps_reg};
    assign quot_next = {quot_reg[FRAC_BITS-2:0], rem_ge};
    assign unit_mag  = {1'b1, {FRAC_BITS{1'b0}}};
    assign minor_mag = eq_reg ? unit_mag : {1'b0, quot_next};

    assign prod_x = PROD_BITS'(accum_x_reg) * PROD_BITS'(cell_scale_reg);
    assign prod_y = PROD_BITS'(accum_y_reg) * PROD_BITS'(cell_scale_reg);
    assign pix_x  = clamp_pixel(prod_x[PROD_BITS-1:FRAC_BITS]);
    assign pix_y  = clamp_pixel(prod_y[PROD_BITS-1:FRAC_BITS]);

    assign sts.steps_zero = (steps_left_reg == '0);

    assign out_data = OUT_DATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign out_last = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_scale_reg <= CELL_SCALE_RESET;
            line_color_reg <= LINE_COLOR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CELL_SCALE: cell_scale_reg <= cfg_data[SCALE_BITS-1:0];
                REG_LINE_COLOR: line_color_reg <= cfg_data;
                default:        line_color_reg <= line_color_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            accum_x_reg    <= {start_x, {FRAC_BITS{1'b0}}};
            accum_y_reg    <= {start_y, {FRAC_BITS{1'b0}}};
            neg_x_reg      <= neg_x;
            neg_y_reg      <= neg_y;
            steps_left_reg <= steps;
            steps_reg      <= steps;
            rem_reg        <= {1'b0, minor};
            quot_reg       <= '0;
            eq_reg         <= (minor == steps);
            zero_reg       <= (steps == '0);
            x_major_reg    <= x_major;
        end
        else if (cmd.step)
        begin
            out_x_reg     <= pix_x;
            out_y_reg     <= pix_y;
            out_color_reg <= line_color_reg;
            out_last_reg  <= sts.steps_zero;
            if (!sts.steps_zero)
            begin
                steps_left_reg <= steps_left_reg - 1'b1;
                accum_x_reg    <= neg_x_reg ? (accum_x_reg - ACC_BITS'(step_x_mag_reg))
                                            : (accum_x_reg + ACC_BITS'(step_x_mag_reg));
                accum_y_reg    <= neg_y_reg ? (accum_y_reg - ACC_BITS'(step_y_mag_reg))
                                            : (accum_y_reg + ACC_BITS'(step_y_mag_reg));
            end
        end

        if (cmd.div)
        begin
            rem_reg  <= rem_ge ? (rem_sh - {1'b0, steps_reg}) : rem_sh;
            quot_reg <= quot_next;
        end

        if (cmd.div_last)
        begin
            if (zero_reg)
            begin
                step_x_mag_reg <= '0;
                step_y_mag_reg <= '0;
            end
            else if (x_major_reg)
            begin
                step_x_mag_reg <= unit_mag;
                step_y_mag_reg <= minor_mag;
            end
            else
            begin
                step_x_mag_reg <= minor_mag;
                step_y_mag_reg <= unit_mag;
            end
        end
    end

endmodule

/* rtl/dda_line_pixel_stepper.sv */
// ----------------------------------------------------------------------------
// dda_line_pixel_stepper
// DDA line rasterizer: loads a line, then gives one scaled pixel per step.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   tuser operation, tdata line end points
// m_*      out        m_tvalid/m_tready   tdata pixel x, y, color; tlast last pixel
// cfg_*    in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Step transaction: its pixel is registered at the accepting edge and
// offered on m_* from the next cycle.
// Load transaction: the shift-subtract divider then forms the minor-axis
// increment one quotient bit per cycle, with s_tready low until it is done.
// Reset: asynchronous, active low; cell_scale = 1, line_color = 0xFF0000, idle.
// Stalls: s_tready holds low while the divider runs or a held pixel is not taken.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dda_pkg::IN_DATA_BITS-1:0]    s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                                s_tuser,   // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dda_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [dda_pkg::COLOR_BITS-1:0]      cfg_data
);
    import dda_pkg::*;

    dda_cmd_t cmd;
    dda_sts_t sts;

    assign cfg_ready = 1'b1;

    dda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dda_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* rtl/dda_checker.sv */
// ----------------------------------------------------------------------------
// dda_checker
// Port-level assertions for the DDA line pixel stepper, bound to the top.
// ----------------------------------------------------------------------------
`include "dda_line_pixel_stepper_assert.svh"

module dda_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dda_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input logic                                m_tlast
);
    import dda_pkg::*;

    logic load_fire;
    logic m_stall;

    assign load_fire = s_tvalid && s_tready && (s_tuser == OP_LOAD);
    assign m_stall   = m_tvalid && !m_tready;

    `DDA_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid, "pixel dropped while stalled")
    `DDA_ASSERT_NEXT(a_out_stable, m_stall, $stable({m_tdata, m_tlast}), "pixel changed in stall")
    `DDA_ASSERT_NEXT(a_load_busy, load_fire, !s_tready, "input taken during division")
    `DDA_ASSERT_NEXT(a_load_quiet, load_fire && !m_stall, !m_tvalid, "load produced a pixel")
    `DDA_ASSERT_SAME(a_no_overrun, s_tready, !m_stall, "input taken over a held pixel")

endmodule

bind dda_line_pixel_stepper dda_checker u_dda_checker (.*);

/* tb/dda_line_pixel_stepper_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_pixel_stepper_test
// Self-checking testbench for the DDA line pixel stepper. Lines are loaded and
// stepped through the input stream while a scoreboard class tracks the
// fixed-point accumulators and predicts every pixel. Pixels leaving the output
// stream are checked field by field in order. Sender bursts, receiver stalls,
// long output hold-offs and register changes between phases are included.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper_test;

    import dda_pkg::*;

    localparam int ITEM_TARGET  = 850;
    localparam int DRAIN_CYCLES = 40;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [PIX_BITS-1:0]   x;
        logic [PIX_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    class line_pixel_model;
        logic [SCALE_BITS-1:0]   scale;
        logic [COLOR_BITS-1:0]   color;
        logic [ACC_BITS-1:0]     acc_x;
        logic [ACC_BITS-1:0]     acc_y;
        logic signed [ACC_BITS:0] inc_x;
        logic signed [ACC_BITS:0] inc_y;
        logic [10:0]             steps_left;
        logic                    drawing;
        pixel_t                  pending_pixels[$];
        int                      errors;

        function new();
            scale      = CELL_SCALE_RESET;
            color      = LINE_COLOR_RESET;
            acc_x      = '0;
            acc_y      = '0;
            inc_x      = '0;
            inc_y      = '0;
            steps_left = '0;
            drawing    = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COLOR_BITS-1:0] data);
            if (idx == REG_CELL_SCALE)
                scale = data[SCALE_BITS-1:0];
            else
                color = data;
        endfunction

        function logic signed [ACC_BITS:0] increment(int delta, int steps);
            longint q;
            if (steps == 0)
                return '0;
            q = (longint'(delta < 0 ? -delta : delta) << FRAC_BITS) / steps;
            return (ACC_BITS + 1)'(delta < 0 ? -q : q);
        endfunction

        function logic [PIX_BITS-1:0] screen(logic [ACC_BITS-1:0] acc);
            longint v;
            v = (longint'(acc) * longint'(scale)) >>> FRAC_BITS;
            if (v > longint'(PIXEL_MAX))
                return PIXEL_MAX;
            return v[PIX_BITS-1:0];
        endfunction

        function void take_item(logic op, logic [IN_DATA_BITS-1:0] data);
            int     sx;
            int     sy;
            int     dx;
            int     dy;
            int     ax;
            int     ay;
            int     steps;
            pixel_t p;
            if (op == OP_LOAD)
            begin
                sx    = int'(data[COORD_BITS-1:0]);
                sy    = int'(data[2*COORD_BITS-1:COORD_BITS]);
                dx    = int'(data[3*COORD_BITS-1:2*COORD_BITS]) - sx;
                dy    = int'(data[4*COORD_BITS-1:3*COORD_BITS]) - sy;
                ax    = dx < 0 ? -dx : dx;
                ay    = dy < 0 ? -dy : dy;
                steps = ax > ay ? ax : ay;
                inc_x = increment(dx, steps);
                inc_y = increment(dy, steps);
                acc_x = {data[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
                acc_y = {data[2*COORD_BITS-1:COORD_BITS], {FRAC_BITS{1'b0}}};
                steps_left = steps[10:0];
                drawing    = 1'b1;
                return;
            end
            if (!drawing)
                return;
            p.x     = screen(acc_x);
            p.y     = screen(acc_y);
            p.color = color;
            p.last  = (steps_left == 0);
            if (p.last)
            begin
                drawing = 1'b0;
            end
            else
            begin
                steps_left = steps_left - 1'b1;
                acc_x      = acc_x + inc_x[ACC_BITS-1:0];
                acc_y      = acc_y + inc_y[ACC_BITS-1:0];
            end
            pending_pixels.push_back(p);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_p;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d color=%06h last=%0d",
                       got.x, got.y, got.color, got.last);
                errors++;
                return;
            end
            exp_p = pending_pixels.pop_front();
            if (got.x !== exp_p.x)
            begin
                $error("pixel_x: expected %0d, actual %0d", exp_p.x, got.x);
                errors++;
            end
            if (got.y !== exp_p.y)
            begin
                $error("pixel_y: expected %0d, actual %0d", exp_p.y, got.y);
                errors++;
            end
            if (got.color !== exp_p.color)
            begin
                $error("pixel_color: expected %06h, actual %06h", exp_p.color, got.color);
                errors++;
            end
            if (got.last !== exp_p.last)
            begin
                $error("last_pixel: expected %0d, actual %0d", exp_p.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [COLOR_BITS-1:0]    cfg_data;

    line_pixel_model model = new();

    int items_sent;
    int loads_sent;
    int pixels_seen;
    int reg_writes;
    int burst_left;
    int cycles;

    dda_line_pixel_stepper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            model.check_pixel({m_tdata[PIX_BITS-1:0],
                               m_tdata[2*PIX_BITS-1:PIX_BITS],
                               m_tdata[2*PIX_BITS+COLOR_BITS-1:2*PIX_BITS],
                               m_tlast});
            pixels_seen++;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("dda_line_pixel_stepper test failed");
        $finish;
    end

    // Receiver: random stall modes, plus two long hold-offs to back up the input.
    initial
    begin
        int hold_left;
        int holds_done;
        int next_hold_at;
        int mode;
        int mode_left;
        hold_left    = 0;
        holds_done   = 0;
        next_hold_at = 150;
        mode         = 0;
        mode_left    = 0;
        m_tready     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (holds_done < 2 && pixels_seen >= next_hold_at)
            begin
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
                next_hold_at = next_hold_at + 350;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cycles[2] ^ cycles[0];
                endcase
            end
        end
    end

    task automatic send_item(input logic op, input logic [COORD_BITS-1:0] sx,
                             input logic [COORD_BITS-1:0] sy, input logic [COORD_BITS-1:0] ex,
                             input logic [COORD_BITS-1:0] ey);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tuser  <= op;
        s_tdata  <= {ey, ex, sy, sx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model.take_item(op, {ey, ex, sy, sx});
        items_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_step();
        send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (model.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COLOR_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int ax;
        int ay;
        int steps;
        int n;
        int phases;
        logic [SCALE_BITS-1:0] scale_pick;
        logic [COLOR_BITS-1:0] color_pick;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        cfg_valid   = 1'b0;
        cfg_index   = REG_CELL_SCALE;
        cfg_data    = '0;
        items_sent  = 0;
        loads_sent  = 0;
        pixels_seen = 0;
        reg_writes  = 0;
        burst_left  = 0;
        cycles      = 0;
        phases      = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_step();
        send_item(OP_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_step();
        send_step();
        send_item(OP_LOAD, 10'd0, 10'd0, 10'd1023, 10'd0);
        repeat (3) send_step();
        send_item(OP_LOAD, 10'd1023, 10'd1023, 10'd1020, 10'd1021);
        repeat (5) send_step();
        send_item(OP_LOAD, 10'd0, 10'd1023, 10'd5, 10'd0);
        repeat (2) send_step();
        send_item(OP_LOAD, 10'h200, 10'h155, 10'h2AA, 10'h0AA);
        repeat (2) send_step();

        wait_drained();
        write_cfg(REG_CELL_SCALE, 24'd31);
        write_cfg(REG_LINE_COLOR, 24'h000000);
        repeat (2) send_step();
        wait_drained();
        write_cfg(REG_CELL_SCALE, 24'd0);
        write_cfg(REG_LINE_COLOR, 24'hFFFFFF);
        repeat (2) send_step();

        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            case ($urandom_range(0, 7))
                0:       scale_pick = 5'd0;
                1:       scale_pick = 5'd1;
                2:       scale_pick = 5'd16;
                3:       scale_pick = 5'd31;
                default: scale_pick = SCALE_BITS'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
                0:       color_pick = 24'h000000;
                1:       color_pick = 24'hFFFFFF;
                default: color_pick = COLOR_BITS'($urandom);
            endcase
            write_cfg(REG_CELL_SCALE, {{(COLOR_BITS-SCALE_BITS){1'b0}}, scale_pick});
            write_cfg(REG_LINE_COLOR, color_pick);
            phases++;
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(1'($urandom_range(0, 1)),
                              COORD_BITS'($urandom), COORD_BITS'($urandom),
                              COORD_BITS'($urandom), COORD_BITS'($urandom));
                end
                else
                begin
                    sx   = $urandom_range(0, 1023);
                    sy   = $urandom_range(0, 1023);
                    span = ($urandom_range(0, 9) == 0) ? 150 : 12;
                    if ($urandom_range(0, 29) == 0)
                        span = 1023;
                    ex = sx + $urandom_range(0, 2 * span) - span;
                    ey = sy + $urandom_range(0, 2 * span) - span;
                    ex = ex < 0 ? 0 : (ex > 1023 ? 1023 : ex);
                    ey = ey < 0 ? 0 : (ey > 1023 ? 1023 : ey);
                    ax    = ex > sx ? ex - sx : sx - ex;
                    ay    = ey > sy ? ey - sy : sy - ey;
                    steps = ax > ay ? ax : ay;
                    n     = steps + 1;
                    case ($urandom_range(0, 7))
                        0:       n = $urandom_range(0, steps);
                        1:       n = n + $urandom_range(1, 3);
                        default: n = n;
                    endcase
                    if (span == 1023 && n > 40)
                        n = 40;
                    send_item(OP_LOAD, COORD_BITS'(sx), COORD_BITS'(sy),
                              COORD_BITS'(ex), COORD_BITS'(ey));
                    repeat (n) send_step();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d input items (%0d line loads), %0d pixels checked",
                 items_sent, loads_sent, pixels_seen);
        $display("%0d register writes over %0d random settings, %0d mismatches",
                 reg_writes, phases, model.errors);
        if (model.errors == 0 && model.pending() == 0)
            $display("dda_line_pixel_stepper test passed");
        else
            $display("dda_line_pixel_stepper test failed");
        $finish;
    end

endmodule
